/* hw/rtl/trf_pkg.sv */
// ----------------------------------------------------------------------------
// trf_pkg - shared types and constants of the tile rotate/flip engine
// Field widths, action codes, register indexes and the transfer position
// struct passed from the address unit to the sequencer.
// ----------------------------------------------------------------------------
package trf_pkg;

	// fixed field widths
	localparam int SIDE_W    = 4;   // grid width / height
	localparam int IDX_W     = 6;   // cell_index field
	localparam int VAL_W     = 8;   // cell_value / read_value fields
	localparam int ACT_W     = 3;   // action field
	localparam int PROD_W    = 8;   // side times side, linear positions
	localparam int CFG_IDX_W = 1;   // register index
	localparam int CFG_W     = 4;   // widest register

	// parameter defaults
	localparam int DEF_MAX_SIDE   = 8;
	localparam int DEF_VALUE_BITS = 8;

	// side after reset, for the grid and both start registers
	localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(5);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_W = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_H = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE   = 3'd0,
		ACT_READ    = 3'd1,
		ACT_ROT_R   = 3'd2,
		ACT_ROT_L   = 3'd3,
		ACT_ROT_180 = 3'd4,
		ACT_FLIP_H  = 3'd5,
		ACT_FLIP_V  = 3'd6,
		ACT_INIT    = 3'd7
	} action_t;

	// one step of a grid transform: source, destination, final step
	typedef struct packed {
		logic [PROD_W-1:0] src;
		logic [PROD_W-1:0] dst;
		logic              last;
	} xfer_pos_t;

endpackage

/* hw/rtl/trf_store.sv */
// ----------------------------------------------------------------------------
// trf_store - ping-pong element store
// Two banks of cells. One bank holds the current grid; a transform reads it
// and writes the other bank, which then becomes the grid. Read data is
// registered.
// ----------------------------------------------------------------------------
module trf_store #(
	parameter int VALUE_BITS = trf_pkg::DEF_VALUE_BITS,
	parameter int CELLS      = trf_pkg::DEF_MAX_SIDE * trf_pkg::DEF_MAX_SIDE,
	parameter int ADDR_W     = 6
) (
	input  logic                  clk,
	input  logic                  bank,      // bank holding the current grid
	input  logic                  xfer,      // write goes to the other bank
	input  logic [ADDR_W-1:0]     rd_addr,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [VALUE_BITS-1:0] wr_data,
	output logic [VALUE_BITS-1:0] rd_data
);

	logic [VALUE_BITS-1:0] bank0_q [CELLS];
	logic [VALUE_BITS-1:0] bank1_q [CELLS];
	logic [VALUE_BITS-1:0] rd0_q;
	logic [VALUE_BITS-1:0] rd1_q;
	logic                  rsel_q;
	logic                  wr_bank;

	assign wr_bank = xfer ? ~bank : bank;

	// write the selected bank
	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			bank0_q[wr_addr] <= wr_data;
		end
		if (wr_en && wr_bank) begin
			bank1_q[wr_addr] <= wr_data;
		end
	end

	// read both banks, pick the grid bank after the register
	always_ff @(posedge clk) begin
		rd0_q  <= bank0_q[rd_addr];
		rd1_q  <= bank1_q[rd_addr];
		rsel_q <= bank;
	end

	assign rd_data = rsel_q ? rd1_q : rd0_q;

endmodule

/* hw/rtl/trf_addr_unit.sv */
// ----------------------------------------------------------------------------
// trf_addr_unit - transform address generator
// Walks the new grid row-major and computes the source cell of each step
// with one shared multiply-add against the old width; the half turn mirrors the linear position instead.
// ----------------------------------------------------------------------------
module trf_addr_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          adv,
	input  trf_pkg::action_t              mode,
	input  logic [trf_pkg::SIDE_W-1:0]    old_w,
	input  logic [trf_pkg::SIDE_W-1:0]    old_h,
	input  logic [trf_pkg::PROD_W-1:0]    cells_n,
	output trf_pkg::xfer_pos_t            pos
);

	import trf_pkg::*;

	action_t           mode_q;
	logic [SIDE_W-1:0] ow_q;
	logic [SIDE_W-1:0] oh_q;
	logic [SIDE_W-1:0] nw_q;
	logic [PROD_W-1:0] n_q;
	logic [SIDE_W-1:0] r_q;
	logic [SIDE_W-1:0] c_q;
	logic [PROD_W-1:0] dst_q;
	logic [SIDE_W-1:0] mul_a;
	logic [SIDE_W-1:0] addend;
	logic [PROD_W-1:0] prod;
	logic              rotate;

	assign rotate = (mode == ACT_ROT_R) || (mode == ACT_ROT_L);

	// latch the transform on load
	always_ff @(posedge clk) begin
		if (load) begin
			mode_q <= mode;
			ow_q   <= old_w;
			oh_q   <= old_h;
			nw_q   <= rotate ? old_h : old_w;
			n_q    <= cells_n;
		end
	end

	// advance row, column and destination counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			c_q   <= '0;
			dst_q <= '0;
		end else if (load) begin
			r_q   <= '0;
			c_q   <= '0;
			dst_q <= '0;
		end else if (adv) begin
			dst_q <= dst_q + PROD_W'(1);
			if (c_q == nw_q - SIDE_W'(1)) begin
				c_q <= '0;
				r_q <= r_q + SIDE_W'(1);
			end else begin
				c_q <= c_q + SIDE_W'(1);
			end
		end
	end

	// pick multiplier and addend operands for the mode
	always_comb begin
		unique case (mode_q)
			ACT_ROT_R: begin
				mul_a  = oh_q - SIDE_W'(1) - c_q;
				addend = r_q;
			end
			ACT_ROT_L: begin
				mul_a  = c_q;
				addend = ow_q - SIDE_W'(1) - r_q;
			end
			ACT_FLIP_H: begin
				mul_a  = r_q;
				addend = ow_q - SIDE_W'(1) - c_q;
			end
			default: begin
				mul_a  = oh_q - SIDE_W'(1) - r_q;
				addend = c_q;
			end
		endcase
	end

	// shared multiply-add; the half turn mirrors the linear position
	assign prod    = PROD_W'(mul_a) * PROD_W'(ow_q);
	assign pos.src = (mode_q == ACT_ROT_180) ? (n_q - PROD_W'(1) - dst_q)
	                                         : (prod + PROD_W'(addend));
	assign pos.dst  = dst_q;
	assign pos.last = (dst_q == n_q - PROD_W'(1));

endmodule

/* hw/rtl/tile_rotate_flip_engine_unit.sv */
// ----------------------------------------------------------------------------
// tile_rotate_flip_engine_unit - small grid with rotate and flip actions
// Row-major grid of elements with a current width and height. Actions write
// or read one cell, rotate the grid by 90 (either way) or 180 degrees, mirror
// it, or start a new grid with the configured sizes.
//
//   port group   dir  handshake        payload
//   ----------   ---  ---------------  ----------------------------------------
//   command      in   start / busy     action, cell_index, cell_value
//   result       out  done strobe      read_value, width_now, height_now,
//                                      index_error
//   config       in   cfg_we           cfg_index, cfg_wdata
//
// Write, read and init: done one cycle after the accepting edge.
// Transforms: states S_XFER, S_TAIL and S_FIN in that order; the
// address unit and the single read port of the store move one cell a cycle.
// A new command is taken in the cycle in which done is high.
// Reset sets the grid and both start registers to 5x5; no clearing pass.
// Results cannot be stalled: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module tile_rotate_flip_engine_unit #(
	parameter int MAX_SIDE   = trf_pkg::DEF_MAX_SIDE,
	parameter int VALUE_BITS = trf_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [trf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trf_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             start,
	input  logic [trf_pkg::ACT_W-1:0]        action,
	input  logic [trf_pkg::IDX_W-1:0]        cell_index,
	input  logic [trf_pkg::VAL_W-1:0]        cell_value,
	output logic                             busy,
	output logic                             done,
	output logic [trf_pkg::VAL_W-1:0]        read_value,
	output logic [trf_pkg::SIDE_W-1:0]       width_now,
	output logic [trf_pkg::SIDE_W-1:0]       height_now,
	output logic                             index_error
);

	import trf_pkg::*;

	localparam int CELLS  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [PROD_W:0]     CELLS_EXT = (PROD_W + 1)'(CELLS);
	localparam logic [SIDE_W:0]     SIDE_MAX  = (SIDE_W + 1)'(MAX_SIDE);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_XFER = 4'b0010,
		S_TAIL = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	action_t           act_in;
	action_t           act_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SIDE_W-1:0] start_w_q;
	logic [SIDE_W-1:0] start_h_q;
	logic [SIDE_W-1:0] w_q;
	logic [SIDE_W-1:0] h_q;
	logic [SIDE_W-1:0] init_w;
	logic [SIDE_W-1:0] init_h;
	logic              bank_q;
	logic              accept;
	logic              is_xform;
	logic              xfer_mode;
	logic [PROD_W-1:0] area;
	logic [PROD_W-1:0] in_idx_ext;
	logic [PROD_W-1:0] q_idx_ext;
	logic              in_ok;
	logic              fin_err;
	xfer_pos_t         pos;
	logic              wen_s1;
	logic              zero_s1;
	logic [PROD_W-1:0] dst_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [VALUE_BITS-1:0] rd_data;
	logic              done_q;
	logic [VAL_W-1:0]  read_value_q;
	logic              index_error_q;

	assign act_in   = action_t'(action);
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_xform = (act_in != ACT_WRITE) && (act_in != ACT_READ) &&
	                  (act_in != ACT_INIT);
	assign xfer_mode = (state_q == S_XFER) || (state_q == S_TAIL);

	assign area       = PROD_W'(w_q) * PROD_W'(h_q);
	assign in_idx_ext = PROD_W'(cell_index);
	assign q_idx_ext  = PROD_W'(idx_q);
	assign in_ok      = (in_idx_ext < area) && ({1'b0, in_idx_ext} < CELLS_EXT);
	assign fin_err    = !(q_idx_ext < area);

	// saturate the start sizes to 1..MAX_SIDE
	assign init_w = (start_w_q == '0) ? SIDE_W'(1) :
	                (({1'b0, start_w_q}) > SIDE_MAX) ? SIDE_W'(MAX_SIDE) : start_w_q;
	assign init_h = (start_h_q == '0) ? SIDE_W'(1) :
	                (({1'b0, start_h_q}) > SIDE_MAX) ? SIDE_W'(MAX_SIDE) : start_h_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_w_q <= RESET_SIDE;
			start_h_q <= RESET_SIDE;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_W) begin
				start_w_q <= cfg_wdata;
			end
			if (cfg_index == CFG_START_H) begin
				start_h_q <= cfg_wdata;
			end
		end
	end

	// hold the command payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= act_in;
			idx_q <= cell_index;
		end
	end

	// sequencer, grid sizes and bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= RESET_SIDE;
			h_q     <= RESET_SIDE;
			bank_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (act_in == ACT_INIT) begin
							w_q <= init_w;
							h_q <= init_h;
						end
						state_q <= is_xform ? S_XFER : S_FIN;
					end
				end
				S_XFER: begin
					if (pos.last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					bank_q <= ~bank_q;
					if ((act_q == ACT_ROT_R) || (act_q == ACT_ROT_L)) begin
						w_q <= h_q;
						h_q <= w_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// address unit: one source position per cycle
	trf_addr_unit u_addr (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept && is_xform),
		.adv     (state_q == S_XFER),
		.mode    (act_in),
		.old_w   (w_q),
		.old_h   (h_q),
		.cells_n (area),
		.pos     (pos)
	);

	// align the destination with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wen_s1 <= 1'b0;
		end else begin
			wen_s1 <= (state_q == S_XFER) && ({1'b0, pos.dst} < CELLS_EXT);
		end
	end

	always_ff @(posedge clk) begin
		dst_s1  <= pos.dst;
		zero_s1 <= !({1'b0, pos.src} < CELLS_EXT);
	end

	// store port steering
	assign rd_addr = (state_q == S_XFER) ? pos.src[ADDR_W-1:0] : in_idx_ext[ADDR_W-1:0];
	assign wr_en   = xfer_mode ? wen_s1 : (accept && (act_in == ACT_WRITE) && in_ok);
	assign wr_addr = xfer_mode ? dst_s1[ADDR_W-1:0] : in_idx_ext[ADDR_W-1:0];
	assign wr_data = xfer_mode ? (zero_s1 ? '0 : rd_data) : VALUE_BITS'(cell_value);

	trf_store #(
		.VALUE_BITS (VALUE_BITS),
		.CELLS      (CELLS),
		.ADDR_W     (ADDR_W)
	) u_store (
		.clk     (clk),
		.bank    (bank_q),
		.xfer    (xfer_mode),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			index_error_q <= fin_err;
			if ((act_q == ACT_READ) && !fin_err && ({1'b0, q_idx_ext} < CELLS_EXT)) begin
				read_value_q <= VAL_W'(rd_data);
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign width_now   = w_q;
	assign height_now  = h_q;
	assign index_error = index_error_q;

	// a result transfer only leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// busy only follows an accepted command
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without start");

	// sizes hold while no command is taken
	a_size_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> ($stable(w_q) && $stable(h_q)))
		else $error("grid size changed while idle");

	// last write of a transform leads straight to the result
	a_tail_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAIL) |=> (state_q == S_FIN))
		else $error("tail not followed by finish");

	// a transform never writes the store from the command port
	a_xfer_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XFER) |-> (wr_en == wen_s1))
		else $error("stray write during transform");

endmodule
